>>> rtl/core/mije_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the immediate/branch/jump execute core:
// opcodes, memory access kinds and fixed masks. No dependencies.
package mije_pkg;

    typedef logic [5:0] t_opcode;
    typedef logic [2:0] t_mem_kind;

    localparam t_opcode OP_REGIMM = 6'd1;
    localparam t_opcode OP_J      = 6'd2;
    localparam t_opcode OP_JAL    = 6'd3;
    localparam t_opcode OP_BEQ    = 6'd4;
    localparam t_opcode OP_BNE    = 6'd5;
    localparam t_opcode OP_BLEZ   = 6'd6;
    localparam t_opcode OP_BGTZ   = 6'd7;
    localparam t_opcode OP_ADDI   = 6'd8;
    localparam t_opcode OP_ADDIU  = 6'd9;
    localparam t_opcode OP_SLTI   = 6'd10;
    localparam t_opcode OP_SLTIU  = 6'd11;
    localparam t_opcode OP_ANDI   = 6'd12;
    localparam t_opcode OP_ORI    = 6'd13;
    localparam t_opcode OP_LUI    = 6'd15;
    localparam t_opcode OP_LB     = 6'd32;
    localparam t_opcode OP_LW     = 6'd35;
    localparam t_opcode OP_LBU    = 6'd36;
    localparam t_opcode OP_SB     = 6'd40;
    localparam t_opcode OP_SH     = 6'd41;
    localparam t_opcode OP_SW     = 6'd43;

    localparam t_mem_kind MEM_NONE = 3'd0;
    localparam t_mem_kind MEM_LB   = 3'd1;
    localparam t_mem_kind MEM_LBU  = 3'd2;
    localparam t_mem_kind MEM_LW   = 3'd3;
    localparam t_mem_kind MEM_SB   = 3'd4;
    localparam t_mem_kind MEM_SH   = 3'd5;
    localparam t_mem_kind MEM_SW   = 3'd6;

    localparam logic [4:0]  LINK_REG = 5'd31;
    localparam logic [31:0] SIGN32   = 32'h8000_0000;
    localparam logic [31:0] SEG_MASK = 32'hf000_0000;

    // REGIMM rt field: bit 0 selects GEZ over LTZ, bit 4 selects link
    localparam int REGIMM_GE_BIT   = 0;
    localparam int REGIMM_LINK_BIT = 4;

endpackage

>>> rtl/core/mips_immediate_and_jump_execute_core.sv
`timescale 1ns / 1ps
// Execute core for MIPS-I immediate, branch and jump instructions.
// Depends on mije_pkg for opcodes, memory kinds and masks.
//
// Usage:
//   Command channel: drive the instruction word, rs/rt register values and
//   the held pc (two words past the instruction) with start high; the item
//   transfers at any edge where start is high and busy is low. busy is
//   always low: the core takes one instruction every cycle.
//   Result channel: o_done is high for exactly one cycle with the writeback,
//   next pc, memory request and flags for one instruction, in issue order.
//   Each instruction passes through an input register stage (with pc - 4),
//   an arithmetic stage (immediate add, branch and jump targets, compares)
//   and a select stage into the output register.
//   Throughput is one instruction per cycle.
//   The receiver cannot stall; every result must be taken in its cycle.
//   Configuration: i_cfg_we writes i_cfg_data into the cache-isolate bit;
//   while set, stores produce no memory request. Write it only when idle.
//   Reset (i_rst_n low, synchronous) clears all stage valid bits and the
//   cache-isolate bit; no result is produced until new commands arrive.
module mips_immediate_and_jump_execute_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_instruction,
    input  logic [31:0] i_rs_value,
    input  logic [31:0] i_rt_value,
    input  logic [31:0] i_pc_now,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    output logic        o_done,
    output logic        o_reg_write,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_write_delayed,
    output logic [31:0] o_next_pc,
    output logic        o_branch_taken,
    output logic [2:0]  o_mem_kind,
    output logic [31:0] o_mem_addr,
    output logic [31:0] o_store_data,
    output logic        o_overflow,
    output logic        o_unsupported
);

    logic r_cache_isolated;

    // Stage A: captured command
    logic        r_a_valid;
    logic [31:0] r_a_ins;
    logic [31:0] r_a_rs;
    logic [31:0] r_a_rt;
    logic [31:0] r_a_pc;
    logic [31:0] r_a_pcm4;

    // Stage B: arithmetic results
    logic                 r_b_valid;
    mije_pkg::t_opcode    r_b_op;
    logic [4:0]           r_b_rt_idx;
    logic [15:0]          r_b_imm;
    logic [31:0]          r_b_rt;
    logic [31:0]          r_b_pc;
    logic [31:0]          r_b_sum;
    logic [31:0]          r_b_btarget;
    logic [31:0]          r_b_jtarget;
    logic                 r_b_eq;
    logic                 r_b_slt;
    logic                 r_b_sltu;
    logic                 r_b_ovf;
    logic                 r_b_rs_neg;
    logic                 r_b_rs_zero;
    logic [31:0]          r_b_and;
    logic [31:0]          r_b_or;

    // Output register
    logic        r_done;
    logic        r_wr;
    logic [4:0]  r_idx;
    logic [31:0] r_val;
    logic        r_dly;
    logic [31:0] r_npc;
    logic        r_taken;
    logic [2:0]  r_kind;
    logic [31:0] r_maddr;
    logic [31:0] r_sdata;
    logic        r_ovf;
    logic        r_uns;

    logic [31:0] a_se;
    logic [31:0] a_sum;

    logic        n_wr;
    logic [4:0]  n_idx;
    logic [31:0] n_val;
    logic        n_dly;
    logic [31:0] n_npc;
    logic        n_taken;
    logic [2:0]  n_kind;
    logic [31:0] n_maddr;
    logic [31:0] n_sdata;
    logic        n_ovf;
    logic        n_uns;
    logic        n_is_branch;
    logic        n_cond;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_isolated <= 1'b0;
        end else if (i_cfg_we) begin
            r_cache_isolated <= i_cfg_data;
        end
    end

    // Stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ins  <= i_instruction;
        r_a_rs   <= i_rs_value;
        r_a_rt   <= i_rt_value;
        r_a_pc   <= i_pc_now;
        r_a_pcm4 <= i_pc_now - 32'd4;
    end

    // Stage B
    assign a_se  = {{16{r_a_ins[15]}}, r_a_ins[15:0]};
    assign a_sum = r_a_rs + a_se;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_op      <= r_a_ins[31:26];
        r_b_rt_idx  <= r_a_ins[20:16];
        r_b_imm     <= r_a_ins[15:0];
        r_b_rt      <= r_a_rt;
        r_b_pc      <= r_a_pc;
        r_b_sum     <= a_sum;
        r_b_btarget <= r_a_pcm4 + {a_se[29:0], 2'b00};
        r_b_jtarget <= (r_a_pcm4 & mije_pkg::SEG_MASK) | {4'b0000, r_a_ins[25:0], 2'b00};
        r_b_eq      <= (r_a_rs == r_a_rt);
        r_b_slt     <= (r_a_rs ^ mije_pkg::SIGN32) < (a_se ^ mije_pkg::SIGN32);
        r_b_sltu    <= (r_a_rs < a_se);
        r_b_ovf     <= !(r_a_rs[31] ^ a_se[31]) && (a_sum[31] ^ r_a_rs[31]);
        r_b_rs_neg  <= r_a_rs[31];
        r_b_rs_zero <= (r_a_rs == 32'd0);
        r_b_and     <= r_a_rs & {16'd0, r_a_ins[15:0]};
        r_b_or      <= r_a_rs | {16'd0, r_a_ins[15:0]};
    end

    // Stage C: select the result fields
    always_comb begin
        n_wr        = 1'b0;
        n_idx       = 5'd0;
        n_val       = 32'd0;
        n_dly       = 1'b0;
        n_npc       = r_b_pc;
        n_taken     = 1'b0;
        n_kind      = mije_pkg::MEM_NONE;
        n_maddr     = 32'd0;
        n_sdata     = 32'd0;
        n_ovf       = 1'b0;
        n_uns       = 1'b0;
        n_is_branch = 1'b0;
        n_cond      = 1'b0;
        unique case (r_b_op) inside
            mije_pkg::OP_REGIMM: begin
                n_is_branch = 1'b1;
                n_cond = r_b_rt_idx[mije_pkg::REGIMM_GE_BIT] ? !r_b_rs_neg : r_b_rs_neg;
                if (r_b_rt_idx[mije_pkg::REGIMM_LINK_BIT]) begin
                    n_wr  = 1'b1;
                    n_idx = mije_pkg::LINK_REG;
                    n_val = r_b_pc;
                end
            end
            mije_pkg::OP_J: begin
                n_npc   = r_b_jtarget;
                n_taken = 1'b1;
            end
            mije_pkg::OP_JAL: begin
                n_npc   = r_b_jtarget;
                n_taken = 1'b1;
                n_wr    = 1'b1;
                n_idx   = mije_pkg::LINK_REG;
                n_val   = r_b_pc;
            end
            mije_pkg::OP_BEQ: begin
                n_is_branch = 1'b1;
                n_cond      = r_b_eq;
            end
            mije_pkg::OP_BNE: begin
                n_is_branch = 1'b1;
                n_cond      = !r_b_eq;
            end
            mije_pkg::OP_BLEZ: begin
                n_is_branch = 1'b1;
                n_cond      = r_b_rs_neg || r_b_rs_zero;
            end
            mije_pkg::OP_BGTZ: begin
                n_is_branch = 1'b1;
                n_cond      = !r_b_rs_neg && !r_b_rs_zero;
            end
            mije_pkg::OP_ADDI: begin
                if (r_b_ovf) begin
                    n_ovf = 1'b1;
                end else begin
                    n_wr  = 1'b1;
                    n_idx = r_b_rt_idx;
                    n_val = r_b_sum;
                end
            end
            mije_pkg::OP_ADDIU: begin
                n_wr  = 1'b1;
                n_idx = r_b_rt_idx;
                n_val = r_b_sum;
            end
            mije_pkg::OP_SLTI: begin
                n_wr  = 1'b1;
                n_idx = r_b_rt_idx;
                n_val = {31'd0, r_b_slt};
            end
            mije_pkg::OP_SLTIU: begin
                n_wr  = 1'b1;
                n_idx = r_b_rt_idx;
                n_val = {31'd0, r_b_sltu};
            end
            mije_pkg::OP_ANDI: begin
                n_wr  = 1'b1;
                n_idx = r_b_rt_idx;
                n_val = r_b_and;
            end
            mije_pkg::OP_ORI: begin
                n_wr  = 1'b1;
                n_idx = r_b_rt_idx;
                n_val = r_b_or;
            end
            mije_pkg::OP_LUI: begin
                n_wr  = 1'b1;
                n_idx = r_b_rt_idx;
                n_val = {r_b_imm, 16'd0};
            end
            mije_pkg::OP_LB, mije_pkg::OP_LBU, mije_pkg::OP_LW: begin
                n_wr    = 1'b1;
                n_idx   = r_b_rt_idx;
                n_dly   = 1'b1;
                n_maddr = r_b_sum;
                n_kind  = (r_b_op == mije_pkg::OP_LB)  ? mije_pkg::MEM_LB :
                          (r_b_op == mije_pkg::OP_LBU) ? mije_pkg::MEM_LBU :
                                                         mije_pkg::MEM_LW;
            end
            mije_pkg::OP_SB, mije_pkg::OP_SH, mije_pkg::OP_SW: begin
                // drop the request while the cache is isolated
                if (!r_cache_isolated) begin
                    n_maddr = r_b_sum;
                    if (r_b_op == mije_pkg::OP_SB) begin
                        n_kind  = mije_pkg::MEM_SB;
                        n_sdata = {24'd0, r_b_rt[7:0]};
                    end else if (r_b_op == mije_pkg::OP_SH) begin
                        n_kind  = mije_pkg::MEM_SH;
                        n_sdata = {16'd0, r_b_rt[15:0]};
                    end else begin
                        n_kind  = mije_pkg::MEM_SW;
                        n_sdata = r_b_rt;
                    end
                end
            end
            default: begin
                n_uns = 1'b1;
            end
        endcase
        if (n_is_branch && n_cond) begin
            n_npc   = r_b_btarget;
            n_taken = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr    <= n_wr;
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_dly   <= n_dly;
        r_npc   <= n_npc;
        r_taken <= n_taken;
        r_kind  <= n_kind;
        r_maddr <= n_maddr;
        r_sdata <= n_sdata;
        r_ovf   <= n_ovf;
        r_uns   <= n_uns;
    end

    assign o_done          = r_done;
    assign o_reg_write     = r_wr;
    assign o_reg_index     = r_idx;
    assign o_reg_value     = r_val;
    assign o_write_delayed = r_dly;
    assign o_next_pc       = r_npc;
    assign o_branch_taken  = r_taken;
    assign o_mem_kind      = r_kind;
    assign o_mem_addr      = r_maddr;
    assign o_store_data    = r_sdata;
    assign o_overflow      = r_ovf;
    assign o_unsupported   = r_uns;

endmodule
